// ===== hw/rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master transaction sequencer: bus
// commands, transaction modes, error codes, action and status codes, and the
// operation and result records passed between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam int ADDR_DEPTH = 4;
  localparam int DATA_DEPTH = 32;
  localparam int ADDR_IDX_W = $clog2(ADDR_DEPTH);
  localparam int DATA_IDX_W = $clog2(DATA_DEPTH);
  localparam int ADDR_LEN_W = 3;
  localparam int DATA_LEN_W = 6;
  localparam int IDX_W      = 5;
  localparam int BYTE_W     = 8;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_SEND,
    CMD_RX_ACK,
    CMD_RX_NACK
  } cmd_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_WRITE,
    M_READ,
    M_AWRITE,
    M_AREAD,
    M_AREAD2
  } mode_t;

  typedef enum logic [2:0] {
    E_NONE,
    E_BUS,
    E_MODE,
    E_ANACK,
    E_DNACK,
    E_UNKNOWN
  } err_t;

  localparam logic [1:0] ACT_START     = 2'd0;
  localparam logic [1:0] ACT_LOAD_ADDR = 2'd1;
  localparam logic [1:0] ACT_LOAD_DATA = 2'd2;
  localparam logic [1:0] ACT_EVENT     = 2'd3;

  // Status codes with the low three bits dropped.
  localparam logic [4:0] ST_BUS_ERR    = 5'h00;
  localparam logic [4:0] ST_START      = 5'h01;
  localparam logic [4:0] ST_RSTART     = 5'h02;
  localparam logic [4:0] ST_SLAW_ACK   = 5'h03;
  localparam logic [4:0] ST_SLAW_NACK  = 5'h04;
  localparam logic [4:0] ST_DATAW_ACK  = 5'h05;
  localparam logic [4:0] ST_DATAW_NACK = 5'h06;
  localparam logic [4:0] ST_ARB_LOST   = 5'h07;
  localparam logic [4:0] ST_SLAR_ACK   = 5'h08;
  localparam logic [4:0] ST_SLAR_NACK  = 5'h09;
  localparam logic [4:0] ST_RX_ACK     = 5'h0A;
  localparam logic [4:0] ST_RX_NACK    = 5'h0B;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_LOAD_ADDR,
    OP_LOAD_DATA,
    OP_EV_BUS_ERR,
    OP_EV_START,
    OP_EV_RSTART,
    OP_EV_SLAW_ACK,
    OP_EV_ADDR_NACK,
    OP_EV_DATAW_ACK,
    OP_EV_DATA_NACK,
    OP_EV_ARB_LOST,
    OP_EV_SLAR_ACK,
    OP_EV_RX_ACK,
    OP_EV_RX_NACK,
    OP_EV_UNKNOWN
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [1:0]              req;
    logic [BYTE_W-1:0]       slave_addr;
    logic [ADDR_LEN_W-1:0]   addr_len;
    logic [DATA_LEN_W-1:0]   data_len;
    logic [IDX_W-1:0]        index;
    logic [BYTE_W-1:0]       data_byte;
  } op_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] tx;
    logic              ack;
    logic              rx_store;
    logic [IDX_W-1:0]  rx_index;
    logic [BYTE_W-1:0] rx_data;
    err_t              err;
    logic              busy;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Sequences I2C master transactions from byte-level bus status events,
// answering each start, load or status beat with one result beat.
//
//   Channel   Handshake            Contents
//   input     push / full          action, mode_request, slave_addr,
//                                  addr_count, data_count, load_index,
//                                  load_byte, bus_status, rx_byte
//   result    empty / pop          bus_command, tx_byte, ack_enable, rx_store,
//                                  rx_index, rx_data, error_code, busy_res
//   config    cfg_valid/cfg_ready  cfg_data (ack_own_address)
//
// An input beat is classified and written into a two-entry operation queue
// when it is accepted. The back part executes it when its result queue has
// room and registers the result into that queue, from which the result ports
// are driven. One beat per cycle is sustained while the result side pops. The
// back part executes one operation per cycle while its two-entry result queue
// has room. Reset is synchronous and empties both queues. A stalled result
// side fills the result queue, then the operation queue, and then raises full.
`default_nettype none

module i2c_master_transaction_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action,
  input  wire logic [1:0]  mode_request,
  input  wire logic [7:0]  slave_addr,
  input  wire logic [2:0]  addr_count,
  input  wire logic [5:0]  data_count,
  input  wire logic [4:0]  load_index,
  input  wire logic [7:0]  load_byte,
  input  wire logic [7:0]  bus_status,
  input  wire logic [7:0]  rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       bus_command,
  output logic [7:0]       tx_byte,
  output logic             ack_enable,
  output logic             rx_store,
  output logic [4:0]       rx_index,
  output logic [7:0]       rx_data,
  output logic [2:0]       error_code,
  output logic             busy_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  i2cms_pkg::op_t   op;
  logic             op_empty;
  logic             op_pop;
  i2cms_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  i2cms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .mode_request (mode_request),
    .slave_addr   (slave_addr),
    .addr_count   (addr_count),
    .data_count   (data_count),
    .load_index   (load_index),
    .load_byte    (load_byte),
    .bus_status   (bus_status),
    .rx_byte      (rx_byte),
    .op_pop       (op_pop),
    .op           (op),
    .op_empty     (op_empty)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .op        (op),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .res_pop   (pop),
    .res       (res),
    .res_empty (empty)
  );

  assign bus_command = res.cmd;
  assign tx_byte     = res.tx;
  assign ack_enable  = res.ack;
  assign rx_store    = res.rx_store;
  assign rx_index    = res.rx_index;
  assign rx_data     = res.rx_data;
  assign error_code  = res.err;
  assign busy_res    = res.busy;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_op_queue.sv =====
// ----------------------------------------------------------------------------
// i2cms_op_queue
// Two-entry queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_op_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire i2cms_pkg::op_t  wr_op,
  output logic                 full,
  input  wire logic            pop,
  output i2cms_pkg::op_t       rd_op,
  output logic                 empty
);

  i2cms_pkg::op_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_op   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_front.sv =====
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts input beats, decodes the action and bus status into an operation
// kind, clamps transfer lengths and checks load positions, and queues the
// result for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [1:0]                         action,
  input  wire logic [1:0]                         mode_request,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]       slave_addr,
  input  wire logic [i2cms_pkg::ADDR_LEN_W-1:0]   addr_count,
  input  wire logic [i2cms_pkg::DATA_LEN_W-1:0]   data_count,
  input  wire logic [i2cms_pkg::IDX_W-1:0]        load_index,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]       load_byte,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]       bus_status,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]       rx_byte,
  input  wire logic                               op_pop,
  output i2cms_pkg::op_t                          op,
  output logic                                    op_empty
);

  i2cms_pkg::op_t        op_in;
  i2cms_pkg::op_kind_t   ev_kind;

  always_comb begin
    unique case (bus_status[7:3])
      i2cms_pkg::ST_BUS_ERR:    ev_kind = i2cms_pkg::OP_EV_BUS_ERR;
      i2cms_pkg::ST_START:      ev_kind = i2cms_pkg::OP_EV_START;
      i2cms_pkg::ST_RSTART:     ev_kind = i2cms_pkg::OP_EV_RSTART;
      i2cms_pkg::ST_SLAW_ACK:   ev_kind = i2cms_pkg::OP_EV_SLAW_ACK;
      i2cms_pkg::ST_SLAW_NACK:  ev_kind = i2cms_pkg::OP_EV_ADDR_NACK;
      i2cms_pkg::ST_DATAW_ACK:  ev_kind = i2cms_pkg::OP_EV_DATAW_ACK;
      i2cms_pkg::ST_DATAW_NACK: ev_kind = i2cms_pkg::OP_EV_DATA_NACK;
      i2cms_pkg::ST_ARB_LOST:   ev_kind = i2cms_pkg::OP_EV_ARB_LOST;
      i2cms_pkg::ST_SLAR_ACK:   ev_kind = i2cms_pkg::OP_EV_SLAR_ACK;
      i2cms_pkg::ST_SLAR_NACK:  ev_kind = i2cms_pkg::OP_EV_ADDR_NACK;
      i2cms_pkg::ST_RX_ACK:     ev_kind = i2cms_pkg::OP_EV_RX_ACK;
      i2cms_pkg::ST_RX_NACK:    ev_kind = i2cms_pkg::OP_EV_RX_NACK;
      default:                  ev_kind = i2cms_pkg::OP_EV_UNKNOWN;
    endcase
  end

  always_comb begin
    op_in.req        = mode_request;
    op_in.slave_addr = slave_addr;
    op_in.index      = load_index;
    op_in.addr_len   = (addr_count > i2cms_pkg::ADDR_DEPTH)
                     ? i2cms_pkg::ADDR_LEN_W'(i2cms_pkg::ADDR_DEPTH) : addr_count;
    op_in.data_len   = (data_count > i2cms_pkg::DATA_DEPTH)
                     ? i2cms_pkg::DATA_LEN_W'(i2cms_pkg::DATA_DEPTH) : data_count;
    op_in.data_byte  = (action == i2cms_pkg::ACT_EVENT) ? rx_byte : load_byte;
    unique case (action)
      i2cms_pkg::ACT_START: begin
        op_in.kind = i2cms_pkg::OP_START;
      end
      i2cms_pkg::ACT_LOAD_ADDR: begin
        op_in.kind = (load_index < i2cms_pkg::ADDR_DEPTH)
                   ? i2cms_pkg::OP_LOAD_ADDR : i2cms_pkg::OP_NOP;
      end
      i2cms_pkg::ACT_LOAD_DATA: begin
        op_in.kind = (load_index < i2cms_pkg::DATA_DEPTH)
                   ? i2cms_pkg::OP_LOAD_DATA : i2cms_pkg::OP_NOP;
      end
      default: begin
        op_in.kind = ev_kind;
      end
    endcase
  end

  i2cms_op_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_op (op_in),
    .full  (full),
    .pop   (op_pop),
    .rd_op (op),
    .empty (op_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_back.sv =====
// ----------------------------------------------------------------------------
// i2cms_back
// Carries out queued operations: holds the transaction state and the byte
// stores, issues the next bus command for each operation, and buffers the
// results in a two-entry queue toward the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic            cfg_data,
  input  wire i2cms_pkg::op_t  op,
  input  wire logic            op_empty,
  output logic                 op_pop,
  input  wire logic            res_pop,
  output i2cms_pkg::res_t      res,
  output logic                 res_empty
);

  localparam int DP_EXT_W = i2cms_pkg::DATA_LEN_W + 1;

  logic                                ack_own;
  i2cms_pkg::mode_t                    mode;
  i2cms_pkg::mode_t                    mode_next;
  logic [i2cms_pkg::BYTE_W-1:0]        target;
  logic [i2cms_pkg::BYTE_W-1:0]        target_next;
  logic [i2cms_pkg::ADDR_LEN_W-1:0]    addr_pos;
  logic [i2cms_pkg::ADDR_LEN_W-1:0]    addr_pos_next;
  logic [i2cms_pkg::ADDR_LEN_W-1:0]    addr_len;
  logic [i2cms_pkg::ADDR_LEN_W-1:0]    addr_len_next;
  logic [i2cms_pkg::DATA_LEN_W-1:0]    data_pos;
  logic [i2cms_pkg::DATA_LEN_W-1:0]    data_pos_next;
  logic [i2cms_pkg::DATA_LEN_W-1:0]    data_len;
  logic [i2cms_pkg::DATA_LEN_W-1:0]    data_len_next;
  i2cms_pkg::err_t                     err;
  i2cms_pkg::err_t                     err_next;
  logic [i2cms_pkg::BYTE_W-1:0]        addr_store [i2cms_pkg::ADDR_DEPTH];
  logic [i2cms_pkg::BYTE_W-1:0]        data_store [i2cms_pkg::DATA_DEPTH];

  logic                                fire;
  logic                                addr_ok;
  logic                                data_ok;
  logic                                addr_done;
  logic                                data_done;
  logic [i2cms_pkg::BYTE_W-1:0]        addr_rd;
  logic [i2cms_pkg::BYTE_W-1:0]        data_rd;
  logic [i2cms_pkg::ADDR_LEN_W-1:0]    addr_pos_inc;
  logic [i2cms_pkg::DATA_LEN_W-1:0]    data_pos_inc;
  logic                                last_rx_now;
  logic                                last_rx_after;
  i2cms_pkg::res_t                     r;

  i2cms_pkg::res_t                     res_q [2];
  logic                                res_wr_ptr;
  logic                                res_rd_ptr;
  logic [1:0]                          res_count;
  logic                                res_full;
  logic                                res_take;

  assign res_full  = (res_count == 2'd2);
  assign res_empty = (res_count == 2'd0);
  assign res_take  = res_pop && !res_empty;
  assign res       = res_q[res_rd_ptr];
  assign fire      = !op_empty && !res_full;
  assign op_pop    = fire;

  assign addr_ok   = (addr_pos < i2cms_pkg::ADDR_DEPTH);
  assign data_ok   = (data_pos < i2cms_pkg::DATA_DEPTH);
  assign addr_rd   = addr_ok ? addr_store[addr_pos[i2cms_pkg::ADDR_IDX_W-1:0]] : '0;
  assign data_rd   = data_ok ? data_store[data_pos[i2cms_pkg::DATA_IDX_W-1:0]] : '0;
  assign addr_pos_inc = addr_ok ? addr_pos + 1'b1 : addr_pos;
  assign data_pos_inc = data_ok ? data_pos + 1'b1 : data_pos;
  assign addr_done = (addr_pos >= addr_len);
  assign data_done = (data_pos >= data_len);
  assign last_rx_now   = ((DP_EXT_W'(data_pos) + 1'b1) >= DP_EXT_W'(data_len));
  assign last_rx_after = ((DP_EXT_W'(data_pos_inc) + 1'b1) >= DP_EXT_W'(data_len));

  always_comb begin
    mode_next = mode;
    unique case (op.kind)
      i2cms_pkg::OP_START: begin
        mode_next = i2cms_pkg::mode_t'(3'(op.req) + 3'd1);
      end
      i2cms_pkg::OP_EV_DATAW_ACK: begin
        if (mode == i2cms_pkg::M_WRITE) begin
          if (data_done) begin
            mode_next = i2cms_pkg::M_IDLE;
          end
        end else if (mode == i2cms_pkg::M_AWRITE) begin
          if (addr_done) begin
            mode_next = data_done ? i2cms_pkg::M_IDLE : i2cms_pkg::M_WRITE;
          end
        end else if (mode == i2cms_pkg::M_AREAD) begin
          if (addr_done) begin
            mode_next = i2cms_pkg::M_AREAD2;
          end
        end
      end
      i2cms_pkg::OP_EV_RX_NACK,
      i2cms_pkg::OP_EV_UNKNOWN: begin
        mode_next = i2cms_pkg::M_IDLE;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  always_comb begin
    target_next   = target;
    addr_pos_next = addr_pos;
    addr_len_next = addr_len;
    data_pos_next = data_pos;
    data_len_next = data_len;
    err_next      = err;
    r.cmd         = i2cms_pkg::CMD_NONE;
    r.tx          = '0;
    r.ack         = 1'b0;
    r.rx_store    = 1'b0;
    r.rx_index    = '0;
    r.rx_data     = '0;
    unique case (op.kind)
      i2cms_pkg::OP_START: begin
        err_next      = i2cms_pkg::E_NONE;
        target_next   = op.slave_addr;
        addr_len_next = op.addr_len;
        data_len_next = op.data_len;
        addr_pos_next = '0;
        data_pos_next = '0;
        r.cmd         = i2cms_pkg::CMD_START;
      end
      i2cms_pkg::OP_EV_BUS_ERR: begin
        err_next = i2cms_pkg::E_BUS;
      end
      i2cms_pkg::OP_EV_START,
      i2cms_pkg::OP_EV_RSTART: begin
        if (mode == i2cms_pkg::M_IDLE) begin
          err_next = i2cms_pkg::E_MODE;
        end else begin
          if (mode == i2cms_pkg::M_WRITE || mode == i2cms_pkg::M_AWRITE) begin
            target_next = {target[i2cms_pkg::BYTE_W-1:1], 1'b0};
          end else if (mode == i2cms_pkg::M_AREAD) begin
            target_next = {target[i2cms_pkg::BYTE_W-1:1],
                           op.kind == i2cms_pkg::OP_EV_RSTART};
          end else begin
            target_next = {target[i2cms_pkg::BYTE_W-1:1], 1'b1};
          end
          r.cmd = i2cms_pkg::CMD_SEND;
          r.tx  = target_next;
          r.ack = ack_own;
        end
      end
      i2cms_pkg::OP_EV_SLAW_ACK: begin
        r.ack = ack_own;
        if (mode == i2cms_pkg::M_WRITE) begin
          r.cmd         = i2cms_pkg::CMD_SEND;
          r.tx          = data_rd;
          data_pos_next = data_pos_inc;
        end else if (mode == i2cms_pkg::M_AWRITE || mode == i2cms_pkg::M_AREAD) begin
          r.cmd         = i2cms_pkg::CMD_SEND;
          r.tx          = addr_rd;
          addr_pos_next = addr_pos_inc;
        end else begin
          err_next = i2cms_pkg::E_MODE;
          r.cmd    = i2cms_pkg::CMD_STOP;
        end
      end
      i2cms_pkg::OP_EV_ADDR_NACK: begin
        err_next = i2cms_pkg::E_ANACK;
        r.cmd    = i2cms_pkg::CMD_STOP;
        r.ack    = ack_own;
      end
      i2cms_pkg::OP_EV_DATAW_ACK: begin
        r.ack = ack_own;
        if ((mode == i2cms_pkg::M_WRITE) ||
            (mode == i2cms_pkg::M_AWRITE && addr_done)) begin
          if (data_done) begin
            r.cmd = i2cms_pkg::CMD_STOP;
          end else begin
            r.cmd         = i2cms_pkg::CMD_SEND;
            r.tx          = data_rd;
            data_pos_next = data_pos_inc;
          end
        end else if (mode == i2cms_pkg::M_AREAD && addr_done) begin
          r.cmd = i2cms_pkg::CMD_START;
        end else if (mode == i2cms_pkg::M_AWRITE || mode == i2cms_pkg::M_AREAD) begin
          r.cmd         = i2cms_pkg::CMD_SEND;
          r.tx          = addr_rd;
          addr_pos_next = addr_pos_inc;
        end else begin
          err_next = i2cms_pkg::E_MODE;
          r.cmd    = i2cms_pkg::CMD_STOP;
        end
      end
      i2cms_pkg::OP_EV_DATA_NACK: begin
        err_next = i2cms_pkg::E_DNACK;
        r.cmd    = i2cms_pkg::CMD_STOP;
        r.ack    = ack_own;
      end
      i2cms_pkg::OP_EV_ARB_LOST: begin
        data_pos_next = '0;
        addr_pos_next = '0;
        r.cmd         = i2cms_pkg::CMD_START;
        r.ack         = ack_own;
      end
      i2cms_pkg::OP_EV_SLAR_ACK: begin
        r.cmd = last_rx_now ? i2cms_pkg::CMD_RX_NACK : i2cms_pkg::CMD_RX_ACK;
        r.ack = !last_rx_now;
      end
      i2cms_pkg::OP_EV_RX_ACK: begin
        r.rx_store    = data_ok;
        r.rx_index    = data_ok ? data_pos[i2cms_pkg::IDX_W-1:0] : '0;
        r.rx_data     = data_ok ? op.data_byte : '0;
        data_pos_next = data_pos_inc;
        r.cmd = last_rx_after ? i2cms_pkg::CMD_RX_NACK : i2cms_pkg::CMD_RX_ACK;
        r.ack = !last_rx_after;
      end
      i2cms_pkg::OP_EV_RX_NACK: begin
        r.rx_store = data_ok;
        r.rx_index = data_ok ? data_pos[i2cms_pkg::IDX_W-1:0] : '0;
        r.rx_data  = data_ok ? op.data_byte : '0;
        r.cmd      = i2cms_pkg::CMD_STOP;
        r.ack      = ack_own;
      end
      i2cms_pkg::OP_EV_UNKNOWN: begin
        err_next = i2cms_pkg::E_UNKNOWN;
        r.cmd    = i2cms_pkg::CMD_STOP;
        r.ack    = ack_own;
      end
      default: begin
        r.cmd = i2cms_pkg::CMD_NONE;
      end
    endcase
    r.err  = err_next;
    r.busy = (mode_next != i2cms_pkg::M_IDLE) && (err_next == i2cms_pkg::E_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_own    <= 1'b0;
      mode       <= i2cms_pkg::M_IDLE;
      target     <= '0;
      addr_pos   <= '0;
      addr_len   <= '0;
      data_pos   <= '0;
      data_len   <= '0;
      err        <= i2cms_pkg::E_NONE;
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (cfg_valid) begin
        ack_own <= cfg_data;
      end
      if (fire) begin
        mode       <= mode_next;
        target     <= target_next;
        addr_pos   <= addr_pos_next;
        addr_len   <= addr_len_next;
        data_pos   <= data_pos_next;
        data_len   <= data_len_next;
        err        <= err_next;
        res_wr_ptr <= !res_wr_ptr;
      end
      if (res_take) begin
        res_rd_ptr <= !res_rd_ptr;
      end
      if (fire && !res_take) begin
        res_count <= res_count + 2'd1;
      end else if (res_take && !fire) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q[res_wr_ptr] <= r;
      if (op.kind == i2cms_pkg::OP_LOAD_ADDR) begin
        addr_store[op.index[i2cms_pkg::ADDR_IDX_W-1:0]] <= op.data_byte;
      end
      if (op.kind == i2cms_pkg::OP_LOAD_DATA) begin
        data_store[op.index[i2cms_pkg::DATA_IDX_W-1:0]] <= op.data_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the I2C master transaction sequencer. It fills the address and
// data stores, walks a short table of directed beats and then runs random
// transactions that follow the bus protocol, with some stray and broken
// status codes. Each accepted input beat is run through a model of the
// sequencer in the testbench, and each result beat is compared with the
// oldest expected one. Both sides idle at random, the result side stalls once
// for a long stretch, and the acknowledge register is changed between phases.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cms_pkg::*;

  localparam logic [4:0] ST_UNDEF = 5'h1F;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] req;
    logic [7:0] sa;
    logic [2:0] ac;
    logic [5:0] dc;
    logic [4:0] li;
    logic [7:0] lb;
    logic [7:0] st;
    logic [7:0] rx;
  } beat_in_t;

  typedef struct {
    beat_in_t   beat;
    bit         pinned;
    cmd_t       cmd;
    logic [7:0] tx;
    logic       ack;
    err_t       err;
    logic       busy;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] action = '0;
  logic [1:0] mode_request = '0;
  logic [7:0] slave_addr = '0;
  logic [2:0] addr_count = '0;
  logic [5:0] data_count = '0;
  logic [4:0] load_index = '0;
  logic [7:0] load_byte = '0;
  logic [7:0] bus_status = '0;
  logic [7:0] rx_byte = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] bus_command;
  logic [7:0] tx_byte;
  logic       ack_enable;
  logic       rx_store;
  logic [4:0] rx_index;
  logic [7:0] rx_data;
  logic [2:0] error_code;
  logic       busy_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  i2c_master_transaction_sequencer DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .mode_request (mode_request),
    .slave_addr   (slave_addr),
    .addr_count   (addr_count),
    .data_count   (data_count),
    .load_index   (load_index),
    .load_byte    (load_byte),
    .bus_status   (bus_status),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .bus_command  (bus_command),
    .tx_byte      (tx_byte),
    .ack_enable   (ack_enable),
    .rx_store     (rx_store),
    .rx_index     (rx_index),
    .rx_data      (rx_data),
    .error_code   (error_code),
    .busy_res     (busy_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer state as the testbench sees it.
  mode_t      seq_mode = M_IDLE;
  logic [7:0] tgt_addr = '0;
  logic [7:0] reg_bytes [ADDR_DEPTH];
  logic [7:0] pay_bytes [DATA_DEPTH];
  int         reg_pos = 0;
  int         reg_len = 0;
  int         pay_pos = 0;
  int         pay_len = 0;
  err_t       seq_err = E_NONE;
  logic       ack_own = 1'b0;

  res_t       offered_q [$];
  res_t       result_q [$];
  res_t       last_res;
  int         beats_sent = 0;
  int         bad_cnt = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  dir_row_t   dir_tab [26];

  function automatic res_t beat_cmd(cmd_t c, logic [7:0] b, logic a);
    res_t r;
    r = '0;
    r.cmd = c;
    r.tx = b;
    r.ack = a;
    return r;
  endfunction

  function automatic res_t stop_cmd();
    return beat_cmd(CMD_STOP, 8'h00, ack_own);
  endfunction

  function automatic res_t send_pay();
    logic [7:0] b;
    b = 8'h00;
    if (pay_pos < DATA_DEPTH) begin
      b = pay_bytes[pay_pos];
      pay_pos++;
    end
    return beat_cmd(CMD_SEND, b, ack_own);
  endfunction

  function automatic res_t send_reg();
    logic [7:0] b;
    b = 8'h00;
    if (reg_pos < ADDR_DEPTH) begin
      b = reg_bytes[reg_pos];
      reg_pos++;
    end
    return beat_cmd(CMD_SEND, b, ack_own);
  endfunction

  function automatic res_t pay_or_stop();
    if (pay_pos >= pay_len) begin
      seq_mode = M_IDLE;
      return stop_cmd();
    end
    return send_pay();
  endfunction

  function automatic res_t receive_next();
    if (pay_pos + 1 >= pay_len) return beat_cmd(CMD_RX_NACK, 8'h00, 1'b0);
    return beat_cmd(CMD_RX_ACK, 8'h00, 1'b1);
  endfunction

  function automatic res_t send_target(logic rd);
    tgt_addr[0] = rd;
    return beat_cmd(CMD_SEND, tgt_addr, ack_own);
  endfunction

  function automatic res_t sequence_step(beat_in_t b);
    res_t       r;
    logic [4:0] code;
    logic       dlv;
    logic [4:0] dlv_idx;
    r = beat_cmd(CMD_NONE, 8'h00, 1'b0);
    code = b.st[7:3];
    dlv = 1'b0;
    dlv_idx = '0;
    case (b.action)
      ACT_START: begin
        seq_err = E_NONE;
        seq_mode = mode_t'({1'b0, b.req} + 3'd1);
        tgt_addr = b.sa;
        reg_len = (b.ac > ADDR_DEPTH) ? ADDR_DEPTH : int'(b.ac);
        pay_len = (b.dc > DATA_DEPTH) ? DATA_DEPTH : int'(b.dc);
        reg_pos = 0;
        pay_pos = 0;
        r = beat_cmd(CMD_START, 8'h00, 1'b0);
      end
      ACT_LOAD_ADDR: begin
        if (b.li < ADDR_DEPTH) reg_bytes[b.li[ADDR_IDX_W-1:0]] = b.lb;
      end
      ACT_LOAD_DATA: begin
        if (b.li < DATA_DEPTH) pay_bytes[b.li[DATA_IDX_W-1:0]] = b.lb;
      end
      default: begin
        case (code)
          ST_BUS_ERR: seq_err = E_BUS;
          ST_START, ST_RSTART: begin
            if (seq_mode == M_WRITE || seq_mode == M_AWRITE) r = send_target(1'b0);
            else if (seq_mode == M_AREAD) r = send_target(code == ST_RSTART);
            else if (seq_mode == M_READ || seq_mode == M_AREAD2) r = send_target(1'b1);
            else seq_err = E_MODE;
          end
          ST_SLAW_ACK: begin
            if (seq_mode == M_WRITE) r = send_pay();
            else if (seq_mode == M_AWRITE || seq_mode == M_AREAD) r = send_reg();
            else begin
              seq_err = E_MODE;
              r = stop_cmd();
            end
          end
          ST_SLAW_NACK, ST_SLAR_NACK: begin
            seq_err = E_ANACK;
            r = stop_cmd();
          end
          ST_DATAW_ACK: begin
            if (seq_mode == M_WRITE) begin
              r = pay_or_stop();
            end else if (seq_mode == M_AWRITE) begin
              if (reg_pos >= reg_len) begin
                seq_mode = M_WRITE;
                r = pay_or_stop();
              end else r = send_reg();
            end else if (seq_mode == M_AREAD) begin
              if (reg_pos >= reg_len) begin
                seq_mode = M_AREAD2;
                r = beat_cmd(CMD_START, 8'h00, ack_own);
              end else r = send_reg();
            end else begin
              seq_err = E_MODE;
              r = stop_cmd();
            end
          end
          ST_DATAW_NACK: begin
            seq_err = E_DNACK;
            r = stop_cmd();
          end
          ST_ARB_LOST: begin
            pay_pos = 0;
            reg_pos = 0;
            r = beat_cmd(CMD_START, 8'h00, ack_own);
          end
          ST_SLAR_ACK: r = receive_next();
          ST_RX_ACK: begin
            dlv = (pay_pos < DATA_DEPTH);
            dlv_idx = 5'(pay_pos);
            if (pay_pos < DATA_DEPTH) pay_pos++;
            r = receive_next();
          end
          ST_RX_NACK: begin
            dlv = (pay_pos < DATA_DEPTH);
            dlv_idx = 5'(pay_pos);
            r = stop_cmd();
            seq_mode = M_IDLE;
          end
          default: begin
            r = stop_cmd();
            seq_mode = M_IDLE;
            seq_err = E_UNKNOWN;
          end
        endcase
        if (dlv) begin
          r.rx_store = 1'b1;
          r.rx_index = dlv_idx;
          r.rx_data = b.rx;
        end
      end
    endcase
    r.err = seq_err;
    r.busy = (seq_mode != M_IDLE) && (seq_err == E_NONE);
    return r;
  endfunction

  function automatic beat_in_t rand_beat();
    beat_in_t b;
    b.action = 2'($urandom);
    b.req = 2'($urandom);
    b.sa = 8'($urandom);
    b.ac = 3'($urandom);
    b.dc = 6'($urandom);
    b.li = 5'($urandom);
    b.lb = 8'($urandom);
    b.st = 8'($urandom);
    b.rx = 8'($urandom);
    return b;
  endfunction

  function automatic beat_in_t ev(logic [4:0] code, logic [2:0] low, logic [7:0] rx);
    beat_in_t b;
    b = '0;
    b.action = ACT_EVENT;
    b.st = {code, low};
    b.rx = rx;
    return b;
  endfunction

  function automatic beat_in_t start_beat(logic [1:0] req, logic [7:0] sa, logic [2:0] ac,
                                          logic [5:0] dc);
    beat_in_t b;
    b = '0;
    b.action = ACT_START;
    b.req = req;
    b.sa = sa;
    b.ac = ac;
    b.dc = dc;
    return b;
  endfunction

  function automatic beat_in_t load_beat(logic [1:0] act, logic [4:0] li, logic [7:0] lb);
    beat_in_t b;
    b = '0;
    b.action = act;
    b.li = li;
    b.lb = lb;
    return b;
  endfunction

  task automatic offer(beat_in_t b, bit pinned, res_t want);
    res_t r;
    r = sequence_step(b);
    last_res = r;
    offered_q.push_back(pinned ? want : r);
    action <= b.action;
    mode_request <= b.req;
    slave_addr <= b.sa;
    addr_count <= b.ac;
    data_count <= b.dc;
    load_index <= b.li;
    load_byte <= b.lb;
    bus_status <= b.st;
    rx_byte <= b.rx;
    push <= 1'b1;
    do @(posedge clk); while (full);
    beats_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic offer_beat(beat_in_t b);
    offer(b, 1'b0, '0);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (result_q.size() != 0 || offered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ack_own(logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ack_own = v;
  endtask

  task automatic run_transaction();
    beat_in_t   b;
    res_t       keep;
    logic [4:0] code;
    logic [4:0] prev_code;
    int         steps;
    bit         done;
    repeat ($urandom_range(0, 2)) begin
      b = rand_beat();
      b.action = ($urandom_range(0, 1) == 0) ? ACT_LOAD_ADDR : ACT_LOAD_DATA;
      if (b.action == ACT_LOAD_ADDR && $urandom_range(0, 3) != 0)
        b.li = 5'($urandom_range(0, ADDR_DEPTH - 1));
      offer_beat(b);
    end
    if ($urandom_range(0, 5) == 0) begin
      b = rand_beat();
      b.action = ACT_EVENT;
      offer_beat(b);
    end
    b = rand_beat();
    b.action = ACT_START;
    b.ac = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 2));
    b.dc = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 4));
    offer_beat(b);
    prev_code = ST_BUS_ERR;
    done = 1'b0;
    steps = 0;
    while (!done && steps < 80) begin
      code = ST_BUS_ERR;
      case (last_res.cmd)
        CMD_START: code = (seq_mode == M_AREAD2) ? ST_RSTART : ST_START;
        CMD_SEND: begin
          if (prev_code == ST_START || prev_code == ST_RSTART)
            code = (seq_mode == M_READ || seq_mode == M_AREAD2) ? ST_SLAR_ACK : ST_SLAW_ACK;
          else
            code = ST_DATAW_ACK;
        end
        CMD_RX_ACK: code = ST_RX_ACK;
        CMD_RX_NACK: code = ST_RX_NACK;
        default: done = 1'b1;
      endcase
      if (!done) begin
        if ($urandom_range(0, 15) == 0) code = 5'($urandom_range(0, 31));
        b = rand_beat();
        b.action = ACT_EVENT;
        b.st[7:3] = code;
        prev_code = code;
        offer_beat(b);
        steps++;
        if ($urandom_range(0, 24) == 0) begin
          keep = last_res;
          b = rand_beat();
          b.action = ($urandom_range(0, 1) == 0) ? ACT_LOAD_ADDR : ACT_LOAD_DATA;
          offer_beat(b);
          last_res = keep;
        end
      end
    end
  endtask

  task automatic random_phase(int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) run_transaction();
  endtask

  initial begin
    res_t want;
    dir_tab = '{
      '{ev(ST_BUS_ERR, 3'd0, 8'h00), 1'b1, CMD_NONE, 8'h00, 1'b0, E_BUS, 1'b0},
      '{ev(ST_START, 3'd7, 8'h00), 1'b1, CMD_NONE, 8'h00, 1'b0, E_MODE, 1'b0},
      '{ev(ST_SLAW_ACK, 3'd0, 8'h00), 1'b1, CMD_STOP, 8'h00, 1'b0, E_MODE, 1'b0},
      '{ev(ST_SLAR_ACK, 3'd0, 8'h00), 1'b1, CMD_RX_NACK, 8'h00, 1'b0, E_MODE, 1'b0},
      '{ev(ST_UNDEF, 3'd7, 8'hFF), 1'b1, CMD_STOP, 8'h00, 1'b0, E_UNKNOWN, 1'b0},
      '{load_beat(ACT_LOAD_ADDR, 5'd31, 8'hFF), 1'b1, CMD_NONE, 8'h00, 1'b0, E_UNKNOWN, 1'b0},
      '{start_beat(2'd0, 8'hFF, 3'd7, 6'd63), 1'b1, CMD_START, 8'h00, 1'b0, E_NONE, 1'b1},
      '{ev(ST_START, 3'd0, 8'h00), 1'b1, CMD_SEND, 8'hFE, 1'b0, E_NONE, 1'b1},
      '{ev(ST_SLAW_ACK, 3'd0, 8'h00), 1'b0, CMD_NONE, 8'h00, 1'b0, E_NONE, 1'b0},
      '{ev(ST_DATAW_ACK, 3'd0, 8'h00), 1'b0, CMD_NONE, 8'h00, 1'b0, E_NONE, 1'b0},
      '{ev(ST_DATAW_NACK, 3'd0, 8'h00), 1'b1, CMD_STOP, 8'h00, 1'b0, E_DNACK, 1'b0},
      '{start_beat(2'd1, 8'h00, 3'd0, 6'd2), 1'b1, CMD_START, 8'h00, 1'b0, E_NONE, 1'b1},
      '{ev(ST_START, 3'd0, 8'h00), 1'b1, CMD_SEND, 8'h01, 1'b0, E_NONE, 1'b1},
      '{ev(ST_SLAW_ACK, 3'd0, 8'h00), 1'b1, CMD_STOP, 8'h00, 1'b0, E_MODE, 1'b0},
      '{ev(ST_SLAR_NACK, 3'd0, 8'h00), 1'b1, CMD_STOP, 8'h00, 1'b0, E_ANACK, 1'b0},
      '{start_beat(2'd3, 8'hA4, 3'd2, 6'd1), 1'b1, CMD_START, 8'h00, 1'b0, E_NONE, 1'b1},
      '{ev(ST_START, 3'd0, 8'h00), 1'b1, CMD_SEND, 8'hA4, 1'b0, E_NONE, 1'b1},
      '{ev(ST_SLAW_ACK, 3'd0, 8'h00), 1'b0, CMD_NONE, 8'h00, 1'b0, E_NONE, 1'b0},
      '{ev(ST_ARB_LOST, 3'd0, 8'h00), 1'b1, CMD_START, 8'h00, 1'b0, E_NONE, 1'b1},
      '{ev(ST_START, 3'd0, 8'h00), 1'b1, CMD_SEND, 8'hA4, 1'b0, E_NONE, 1'b1},
      '{ev(ST_SLAW_ACK, 3'd0, 8'h00), 1'b0, CMD_NONE, 8'h00, 1'b0, E_NONE, 1'b0},
      '{ev(ST_DATAW_ACK, 3'd0, 8'h00), 1'b0, CMD_NONE, 8'h00, 1'b0, E_NONE, 1'b0},
      '{ev(ST_DATAW_ACK, 3'd0, 8'h00), 1'b1, CMD_START, 8'h00, 1'b0, E_NONE, 1'b1},
      '{ev(ST_RSTART, 3'd0, 8'h00), 1'b1, CMD_SEND, 8'hA5, 1'b0, E_NONE, 1'b1},
      '{ev(ST_SLAR_ACK, 3'd0, 8'h00), 1'b1, CMD_RX_NACK, 8'h00, 1'b0, E_NONE, 1'b1},
      '{ev(ST_RX_NACK, 3'd0, 8'h3C), 1'b0, CMD_NONE, 8'h00, 1'b0, E_NONE, 1'b0}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_ack_own(1'b0);
    for (int i = 0; i < ADDR_DEPTH; i++)
      offer_beat(load_beat(ACT_LOAD_ADDR, 5'(i), 8'($urandom)));
    for (int i = 0; i < DATA_DEPTH; i++)
      offer_beat(load_beat(ACT_LOAD_DATA, 5'(i), 8'($urandom)));
    foreach (dir_tab[i]) begin
      want = beat_cmd(dir_tab[i].cmd, dir_tab[i].tx, dir_tab[i].ack);
      want.err = dir_tab[i].err;
      want.busy = dir_tab[i].busy;
      offer(dir_tab[i].beat, dir_tab[i].pinned, want);
    end
    wait_drained();
    write_ack_own(1'b1);
    random_phase(150);
    wait_drained();
    write_ack_own(1'b0);
    hold_req = 1'b1;
    random_phase(150);
    wait_drained();
    write_ack_own(1'b1);
    calm = 1'b1;
    random_phase(150);
    wait_drained();
    if (bad_cnt == 0 && result_q.size() == 0 && offered_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, and one long hold-off that backs up the input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (40) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (result_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("result beat with nothing expected: cmd=%0d tx=%02h err=%0d",
                     bus_command, tx_byte, error_code);
        end else begin
          want = result_q.pop_front();
          if (bus_command !== want.cmd || tx_byte !== want.tx || ack_enable !== want.ack ||
              rx_store !== want.rx_store || rx_index !== want.rx_index ||
              rx_data !== want.rx_data || error_code !== want.err ||
              busy_res !== want.busy) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("result mismatch: expected cmd=%0d tx=%02h ack=%0d rxs=%0d rxi=%0d",
                       want.cmd, want.tx, want.ack, want.rx_store, want.rx_index);
              $display("  expected rxd=%02h err=%0d busy=%0d",
                       want.rx_data, want.err, want.busy);
              $display("  got cmd=%0d tx=%02h ack=%0d rxs=%0d rxi=%0d",
                       bus_command, tx_byte, ack_enable, rx_store, rx_index);
              $display("  got rxd=%02h err=%0d busy=%0d",
                       rx_data, error_code, busy_res);
            end
          end
        end
      end
      if (push && !full && offered_q.size() != 0)
        result_q.push_back(offered_q.pop_front());
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
